### rtl/core/tpif_pkg.sv
// Shared types and constants of the time-of-flight point intensity filter.
// No dependencies; the interfaces, the core and the checker use it.
package tpif_pkg;

    localparam int COORD_W = 16;
    localparam int AMP_W   = 16;
    localparam int FOV_W   = 8;
    localparam int INT_W   = 8;

    localparam int SQ_W    = 31;   // largest square is 2^30
    localparam int SUM_W   = 32;   // three squares stay below 2^32
    localparam int PROD_W  = SUM_W + INT_W;

    // floor(p / 1000000) == floor((p >> 6) / 15625); p >> 6 stays below 2^22
    // whenever the result is not saturated, and 15625 is reached by reciprocal.
    localparam int QIN_LSB   = 6;
    localparam int QIN_W     = 22;
    localparam int MAGIC_W   = 23;
    localparam int QPROD_W   = QIN_W + MAGIC_W;
    localparam int DIV_SHIFT = 36;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = 23'd4398047;

    // amplitude * range^2 at or above 256 * 10^6 saturates the intensity
    localparam logic [PROD_W-1:0] SAT_LIMIT = 40'd256000000;

    localparam logic [INT_W-1:0] INT_MAX   = 8'hFF;
    localparam logic [3:0]       FOV_OUT   = 4'hF;

    // register map, word index = paddr[3:2]
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_FOV_EN   = 2'd1;
    localparam logic [1:0] REG_OVF_LVL  = 2'd2;

    localparam logic              MODE_RESET   = 1'b1;
    localparam logic              FOV_EN_RESET = 1'b0;
    localparam logic [AMP_W-1:0]  OVF_RESET    = 16'hFFFF;

    // how the final intensity is chosen for an item
    typedef enum logic [1:0] {
        SEL_CALC = 2'd0,
        SEL_ZERO = 2'd1,
        SEL_MAX  = 2'd2
    } int_sel_t;

endpackage

### rtl/core/tpif_if.sv
// Stream interfaces of the point intensity filter: pixel requests in, points out.
// Depends on tpif_pkg for field widths.
interface tpif_pixel_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tpif_pkg::COORD_W-1:0]  x_mm;
    logic signed [tpif_pkg::COORD_W-1:0]  y_mm;
    logic signed [tpif_pkg::COORD_W-1:0]  z_mm;
    logic        [tpif_pkg::AMP_W-1:0]    amplitude;
    logic        [tpif_pkg::FOV_W-1:0]    fov_code;

    modport source (output valid, x_mm, y_mm, z_mm, amplitude, fov_code, input ready);
    modport sink   (input valid, x_mm, y_mm, z_mm, amplitude, fov_code, output ready);
endinterface

interface tpif_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tpif_pkg::COORD_W-1:0]  point_x;
    logic signed [tpif_pkg::COORD_W-1:0]  point_y;
    logic signed [tpif_pkg::COORD_W-1:0]  point_z;
    logic        [tpif_pkg::INT_W-1:0]    intensity;

    modport source (output valid, point_x, point_y, point_z, intensity, input ready);
    modport sink   (input valid, point_x, point_y, point_z, intensity, output ready);
endinterface

### rtl/core/tof_point_intensity_filter_top.sv
// Time-of-flight point filter with range-squared amplitude compensation.
// Depends on tpif_pkg and the stream interfaces in tpif_if.sv.
//
// One pixel request is taken in every clock cycle while ready is high. Squares,
// their sum, the amplitude product, the reciprocal product for the division by
// one million, and the output register form five register stages, each with a
// valid bit. A stall on the output side holds the stages behind it, while empty
// stages still fill, so ready stays high until the pipeline is full. Pixels that
// the field-of-view check drops are taken in and produce nothing. Configuration
// is to be written over the APB port between bursts of traffic; the block itself
// does not enforce it. pready is always high and reads return the register value.
module tof_point_intensity_filter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    tpif_pixel_if.sink                        pixel_in,
    tpif_point_if.source                      point_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpif_pkg::PADDR_W-1:0]      paddr,
    input  logic [tpif_pkg::PDATA_W-1:0]      pwdata,
    output logic [tpif_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    // configuration registers
    logic                           mode_reg;
    logic                           fov_en_reg;
    logic [tpif_pkg::AMP_W-1:0]     ovf_lvl_reg;
    logic                           cfg_wr;
    logic [1:0]                     cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= tpif_pkg::MODE_RESET;
            fov_en_reg  <= tpif_pkg::FOV_EN_RESET;
            ovf_lvl_reg <= tpif_pkg::OVF_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                tpif_pkg::REG_MODE:    mode_reg    <= pwdata[0];
                tpif_pkg::REG_FOV_EN:  fov_en_reg  <= pwdata[0];
                tpif_pkg::REG_OVF_LVL: ovf_lvl_reg <= pwdata[tpif_pkg::AMP_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            tpif_pkg::REG_MODE:    prdata = {31'd0, mode_reg};
            tpif_pkg::REG_FOV_EN:  prdata = {31'd0, fov_en_reg};
            tpif_pkg::REG_OVF_LVL: prdata = {16'd0, ovf_lvl_reg};
            default:               prdata = '0;
        endcase
    end

    // stage enables: a stage loads when it is empty or its content moves on
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || point_out.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign pixel_in.ready = en1;

    // entry: classify the request
    logic               drop;
    tpif_pkg::int_sel_t sel_in;

    assign drop = fov_en_reg && (pixel_in.fov_code[7:4] == tpif_pkg::FOV_OUT);

    always_comb
    begin
        priority if (!mode_reg)
            sel_in = tpif_pkg::SEL_ZERO;
        else if (pixel_in.amplitude[15:8] == 8'd0)
            sel_in = tpif_pkg::SEL_CALC;
        else if (pixel_in.amplitude >= ovf_lvl_reg)
            sel_in = tpif_pkg::SEL_MAX;
        else
            sel_in = tpif_pkg::SEL_ZERO;
    end

    // payload of each stage
    logic signed [tpif_pkg::COORD_W-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [tpif_pkg::COORD_W-1:0] x2_reg, y2_reg, z2_reg;
    logic signed [tpif_pkg::COORD_W-1:0] x3_reg, y3_reg, z3_reg;
    logic signed [tpif_pkg::COORD_W-1:0] x4_reg, y4_reg, z4_reg;
    logic signed [tpif_pkg::COORD_W-1:0] x5_reg, y5_reg, z5_reg;
    tpif_pkg::int_sel_t                  sel1_reg, sel2_reg, sel3_reg, sel4_reg;
    logic [tpif_pkg::INT_W-1:0]          amp1_reg, amp2_reg;
    logic [tpif_pkg::SQ_W-1:0]           xx1_reg, yy1_reg, zz1_reg;
    logic [tpif_pkg::SUM_W-1:0]          sum2_reg;
    logic [tpif_pkg::PROD_W-1:0]         prod3_reg;
    logic                                sat4_reg;
    logic [tpif_pkg::QPROD_W-1:0]        qprod4_reg;
    logic [tpif_pkg::INT_W-1:0]          int5_reg;

    logic signed [31:0]                  xx_next, yy_next, zz_next;
    logic [tpif_pkg::SUM_W-1:0]          sum_next;
    logic [tpif_pkg::PROD_W-1:0]         prod_next;
    logic [tpif_pkg::QPROD_W-1:0]        qprod_next;
    logic [tpif_pkg::INT_W-1:0]          int_next;

    assign xx_next    = pixel_in.x_mm * pixel_in.x_mm;
    assign yy_next    = pixel_in.y_mm * pixel_in.y_mm;
    assign zz_next    = pixel_in.z_mm * pixel_in.z_mm;
    assign sum_next   = 32'(xx1_reg) + 32'(yy1_reg) + 32'(zz1_reg);
    assign prod_next  = tpif_pkg::PROD_W'(sum2_reg) * tpif_pkg::PROD_W'(amp2_reg);
    assign qprod_next = tpif_pkg::QPROD_W'(prod3_reg[tpif_pkg::QIN_LSB +: tpif_pkg::QIN_W])
                      * tpif_pkg::QPROD_W'(tpif_pkg::DIV_MAGIC);

    always_comb
    begin
        unique case (sel4_reg)
            tpif_pkg::SEL_CALC: int_next = sat4_reg ? tpif_pkg::INT_MAX
                                         : qprod4_reg[tpif_pkg::DIV_SHIFT +: tpif_pkg::INT_W];
            tpif_pkg::SEL_MAX:  int_next = tpif_pkg::INT_MAX;
            default:            int_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pixel_in.valid && !drop;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg   <= pixel_in.x_mm;
            y1_reg   <= pixel_in.y_mm;
            z1_reg   <= pixel_in.z_mm;
            sel1_reg <= sel_in;
            amp1_reg <= pixel_in.amplitude[tpif_pkg::INT_W-1:0];
            xx1_reg  <= xx_next[tpif_pkg::SQ_W-1:0];
            yy1_reg  <= yy_next[tpif_pkg::SQ_W-1:0];
            zz1_reg  <= zz_next[tpif_pkg::SQ_W-1:0];
        end
        if (en2)
        begin
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
            sel2_reg <= sel1_reg;
            amp2_reg <= amp1_reg;
            sum2_reg <= sum_next;
        end
        if (en3)
        begin
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            z3_reg    <= z2_reg;
            sel3_reg  <= sel2_reg;
            prod3_reg <= prod_next;
        end
        if (en4)
        begin
            x4_reg     <= x3_reg;
            y4_reg     <= y3_reg;
            z4_reg     <= z3_reg;
            sel4_reg   <= sel3_reg;
            sat4_reg   <= prod3_reg >= tpif_pkg::SAT_LIMIT;
            qprod4_reg <= qprod_next;
        end
        if (en5)
        begin
            x5_reg   <= x4_reg;
            y5_reg   <= y4_reg;
            z5_reg   <= z4_reg;
            int5_reg <= int_next;
        end
    end

    assign point_out.valid     = v5_reg;
    assign point_out.point_x   = x5_reg;
    assign point_out.point_y   = y5_reg;
    assign point_out.point_z   = z5_reg;
    assign point_out.intensity = int5_reg;

endmodule

### rtl/core/tpif_checker.sv
// Port-level checks for the point intensity filter, bound to the top level.
// Depends on tpif_pkg and tof_point_intensity_filter_top.
module tpif_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tpif_pkg::INT_W-1:0]    out_intensity,
    input logic                          pready
);

    // an empty output register means nothing can be holding the input back
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output register empty");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("point withdrawn while stalled");

    a_int_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_intensity))
        else $error("intensity changed while stalled");

endmodule

bind tof_point_intensity_filter_top tpif_checker u_tpif_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (pixel_in.ready),
    .out_valid     (point_out.valid),
    .out_ready     (point_out.ready),
    .out_intensity (point_out.intensity),
    .pready        (pready)
);
